@@ rtl/sssp_pkg.sv @@
package sssp_pkg;

  // request type codes
  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  localparam int NODE_BITS   = 6;
  localparam int DIST_BITS   = 22;
  localparam int W_IN_BITS   = 16;
  localparam int CNT_BITS    = 7;
  localparam int MAX_NODES   = 64;
  localparam int WEIGHT_BITS = 16;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 22'h3FFFFF;

  // classified request handed from front to back
  typedef struct packed {
    req_type_t              kind;
    logic [NODE_BITS-1:0]   end_a;
    logic [NODE_BITS-1:0]   end_b;
    logic [W_IN_BITS-1:0]   weight;
    logic [NODE_BITS-1:0]   source;
  } cmd_t;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_EDGE,
    ST_EDGE_RD,
    ST_EDGE_RELAX,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/single_source_shortest_path_unit.sv @@
// channel   direction  handshake        payload
// cfg       in         cfg_valid/ready  node_count
// request   in         in_valid/stall   req_type, edge_end_a/b, edge_weight, source_node
// result    out        out_valid/stall  node_index, distance, unreachable, edges_dropped, last
//
// Add and clear requests are taken in the idle state of the back end. A run
// is a series of settle passes for N nodes and E stored edges: each pass scans
// all node distances (scan, scan_end per node), then walks the edge memory
// (edge, edge_rd, edge_relax per edge). Results then go out via emit_rd, emit_wait, emit.
// Reset (rst, synchronous) empties the edge store and sets node_count to 64.
// The two-entry request queue accepts while the back end works or is stalled, until full.
module single_source_shortest_path_unit #(
  parameter int MAX_EDGES   = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  node_count,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [5:0]  edge_end_a,
  input  logic [5:0]  edge_end_b,
  input  logic [15:0] edge_weight,
  input  logic [5:0]  source_node,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  node_index,
  output logic [21:0] distance,
  output logic        unreachable,
  output logic        edges_dropped,
  output logic        last
);

  logic              cmd_valid;
  logic              cmd_take;
  sssp_pkg::cmd_t    cmd;
  logic [6:0]        count_reg;
  logic              busy;

  // node count register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      count_reg <= node_count;
    end
  end

  sssp_front #(.DEPTH(2)) u_front (
    .clk, .rst, .in_valid, .in_stall, .req_type, .edge_end_a, .edge_end_b,
    .edge_weight, .source_node, .cmd_valid, .cmd_take, .cmd
  );

  sssp_back #(
    .MAX_EDGES(MAX_EDGES)
  ) u_back (
    .clk, .rst, .node_count(count_reg), .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .node_index, .distance, .unreachable,
    .edges_dropped, .last, .busy
  );

  // results only appear while the back end is running
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy) else $error("result outside a run");

  // dropped flag is sticky
  a_drop_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(edges_dropped) && !$past(rst) |-> edges_dropped)
    else $error("overflow flag cleared");

  // a stalled result keeps its node index
  a_hold_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_index))
    else $error("stalled result changed");

endmodule

@@ rtl/sssp_front.sv @@
module sssp_front #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic [5:0]           edge_end_a,
  input  logic [5:0]           edge_end_b,
  input  logic [15:0]          edge_weight,
  input  logic [5:0]           source_node,
  output logic                 cmd_valid,
  input  logic                 cmd_take,
  output sssp_pkg::cmd_t       cmd
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sssp_pkg::cmd_t          q [DEPTH];
  logic [PTR_BITS-1:0]     wr_ptr;
  logic [PTR_BITS-1:0]     rd_ptr;
  logic [PTR_BITS:0]       fill;
  logic                    push;
  logic                    pop;
  sssp_pkg::cmd_t          incoming;

  // classify: REQ_NONE requests are dropped here
  always_comb begin
    incoming.kind   = sssp_pkg::req_type_t'(req_type);
    incoming.end_a  = edge_end_a;
    incoming.end_b  = edge_end_b;
    incoming.weight = edge_weight;
    incoming.source = source_node;
  end

  assign in_stall  = (fill == (PTR_BITS+1)'(DEPTH));
  assign push      = in_valid && !in_stall && (req_type != sssp_pkg::REQ_NONE);
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
    end
  end

endmodule

@@ rtl/sssp_back.sv @@
module sssp_back #(
  parameter int MAX_EDGES   = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [6:0]           node_count,
  input  logic                 cmd_valid,
  output logic                 cmd_take,
  input  sssp_pkg::cmd_t       cmd,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [5:0]           node_index,
  output logic [21:0]          distance,
  output logic                 unreachable,
  output logic                 edges_dropped,
  output logic                 last,
  output logic                 busy
);

  localparam int MAX_NODES   = sssp_pkg::MAX_NODES;
  localparam int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS;
  localparam int NB = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FB = $clog2(MAX_EDGES + 1);
  localparam int DB = sssp_pkg::DIST_BITS;
  localparam int EW = 2 * NB + WEIGHT_BITS;

  // edge memory and distance memory
  logic [EW-1:0]   edge_mem [MAX_EDGES];
  logic [DB-1:0]   dist_mem [MAX_NODES];
  logic [EW-1:0]   edge_rd;
  logic [DB-1:0]   dist_rd;

  logic [MAX_NODES-1:0] reached;
  logic [MAX_NODES-1:0] settled;
  logic [FB-1:0]        edge_fill;
  logic                 overflow;

  sssp_pkg::state_t state, state_next;
  logic [NB:0]      scan_idx;
  logic [NB-1:0]    best_u;
  logic [DB-1:0]    best_d;
  logic             found;
  logic [FB-1:0]    edge_idx;
  logic [6:0]       cnt;
  logic [NB:0]      emit_idx;

  // memory port controls
  logic            e_we;
  logic [EB-1:0]   e_waddr;
  logic [EW-1:0]   e_wdata;
  logic [EB-1:0]   e_raddr;
  logic            d_we;
  logic [NB-1:0]   d_waddr;
  logic [DB-1:0]   d_wdata;
  logic [NB-1:0]   d_raddr;

  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_waddr] <= e_wdata;
    end
    edge_rd <= edge_mem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dist_mem[d_waddr] <= d_wdata;
    end
    dist_rd <= dist_mem[d_raddr];
  end

  // edge fields
  logic [NB-1:0]          ea;
  logic [NB-1:0]          eb;
  logic [WEIGHT_BITS-1:0] ew;
  logic                   hit_a;
  logic                   hit_b;
  logic [NB-1:0]          to_node;
  logic [DB:0]            cand_sum;
  logic [DB-1:0]          cand;
  logic                   in_range;

  assign ea = edge_rd[EW-1 -: NB];
  assign eb = edge_rd[EW-NB-1 -: NB];
  assign ew = edge_rd[WEIGHT_BITS-1:0];
  assign in_range = ({1'b0, ea} < (NB+1)'(cnt)) && ({1'b0, eb} < (NB+1)'(cnt));
  assign hit_a = in_range && (ea == best_u);
  assign hit_b = in_range && (eb == best_u);
  assign to_node = hit_a ? eb : ea;
  assign cand_sum = {1'b0, best_d} + (DB+1)'(ew);
  assign cand = cand_sum[DB] ? sssp_pkg::DIST_MAX : cand_sum[DB-1:0];

  // relax step: dist_rd holds the target's distance in ST_EDGE_RELAX
  logic relax_upd;
  assign relax_upd = (hit_a || hit_b) &&
                     (!reached[to_node] || (cand < dist_rd));

  // scan candidate
  logic [NB-1:0] scan_n;
  logic          scan_live;
  logic          scan_hit;
  assign scan_n    = scan_idx[NB-1:0];
  assign scan_live = reached[scan_n] && !settled[scan_n];
  assign scan_hit  = scan_live && (!found || dist_rd < best_d);

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    e_we       = 1'b0;
    e_waddr    = edge_fill[EB-1:0];
    e_wdata    = {cmd.end_a[NB-1:0], cmd.end_b[NB-1:0], cmd.weight[WEIGHT_BITS-1:0]};
    e_raddr    = edge_idx[EB-1:0];
    d_we       = 1'b0;
    d_waddr    = to_node;
    d_wdata    = cand;
    d_raddr    = scan_n;
    case (state)
      sssp_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          case (cmd.kind)
            sssp_pkg::REQ_ADD: begin
              e_we = (edge_fill < FB'(MAX_EDGES));
            end
            sssp_pkg::REQ_RUN: state_next = sssp_pkg::ST_INIT;
            default: ;
          endcase
        end
      end
      sssp_pkg::ST_INIT: begin
        d_we    = 1'b1;
        d_waddr = best_u;
        d_wdata = '0;
        state_next = ({1'b0, best_u} < (NB+1)'(cnt)) ? sssp_pkg::ST_SCAN
                                                     : sssp_pkg::ST_EMIT_RD;
      end
      sssp_pkg::ST_SCAN: begin
        // read issued for scan_idx, compared next cycle
        d_raddr = scan_n;
        state_next = sssp_pkg::ST_SCAN_END;
      end
      sssp_pkg::ST_SCAN_END: begin
        d_raddr = scan_n + 1'b1;
        if (scan_idx == (NB+1)'(cnt - 7'd1)) begin
          state_next = (found || scan_live) ? sssp_pkg::ST_EDGE : sssp_pkg::ST_EMIT_RD;
        end else begin
          state_next = sssp_pkg::ST_SCAN;
        end
      end
      sssp_pkg::ST_EDGE: begin
        e_raddr = edge_idx[EB-1:0];
        state_next = (edge_idx >= edge_fill) ? sssp_pkg::ST_SCAN
                                             : sssp_pkg::ST_EDGE_RD;
      end
      sssp_pkg::ST_EDGE_RD: begin
        d_raddr = to_node;
        state_next = sssp_pkg::ST_EDGE_RELAX;
      end
      sssp_pkg::ST_EDGE_RELAX: begin
        d_we = relax_upd;
        state_next = sssp_pkg::ST_EDGE;
      end
      sssp_pkg::ST_EMIT_RD: begin
        d_raddr = emit_idx[NB-1:0];
        state_next = sssp_pkg::ST_EMIT_WAIT;
      end
      sssp_pkg::ST_EMIT_WAIT: begin
        // keep the read register on the reported node
        d_raddr = emit_idx[NB-1:0];
        state_next = sssp_pkg::ST_EMIT;
      end
      sssp_pkg::ST_EMIT: begin
        d_raddr = emit_idx[NB-1:0];
        if (!out_stall) begin
          state_next = (emit_idx == (NB+1)'(cnt - 7'd1)) ? sssp_pkg::ST_IDLE
                                                         : sssp_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = sssp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sssp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_fill <= '0;
      overflow  <= 1'b0;
      reached   <= '0;
      settled   <= '0;
      scan_idx  <= '0;
      emit_idx  <= '0;
      edge_idx  <= '0;
      found     <= 1'b0;
      best_u    <= '0;
      best_d    <= '0;
      cnt       <= 7'd1;
    end else begin
      case (state)
        sssp_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              sssp_pkg::REQ_ADD: begin
                if (edge_fill < FB'(MAX_EDGES)) edge_fill <= edge_fill + 1'b1;
                else overflow <= 1'b1;
              end
              sssp_pkg::REQ_CLEAR: edge_fill <= '0;
              sssp_pkg::REQ_RUN: begin
                reached  <= '0;
                settled  <= '0;
                best_u   <= cmd.source[NB-1:0];
                cnt      <= (node_count == 7'd0) ? 7'd1 :
                            (node_count > 7'(MAX_NODES)) ? 7'(MAX_NODES) : node_count;
                scan_idx <= '0;
                emit_idx <= '0;
                found    <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        sssp_pkg::ST_INIT: begin
          if ({1'b0, best_u} < (NB+1)'(cnt)) reached[best_u] <= 1'b1;
          scan_idx <= '0;
          found    <= 1'b0;
        end
        sssp_pkg::ST_SCAN_END: begin
          if (scan_hit) begin
            best_u <= scan_n;
            best_d <= dist_rd;
            found  <= 1'b1;
          end
          if (scan_idx == (NB+1)'(cnt - 7'd1)) begin
            scan_idx <= '0;
            edge_idx <= '0;
            if (found || scan_live) begin
              if (scan_hit)
                settled[scan_n] <= 1'b1;
              else
                settled[best_u] <= 1'b1;
            end
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        sssp_pkg::ST_EDGE: begin
          if (edge_idx >= edge_fill) found <= 1'b0;
        end
        sssp_pkg::ST_EDGE_RELAX: begin
          if (relax_upd) reached[to_node] <= 1'b1;
          // both directions: a self-loop gives no change, otherwise at most one hit
          edge_idx <= edge_idx + 1'b1;
        end
        sssp_pkg::ST_EMIT: begin
          if (!out_stall) emit_idx <= emit_idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // emit the result held in the read register
  logic [NB-1:0] e_n;
  assign e_n = emit_idx[NB-1:0];
  assign out_valid     = (state == sssp_pkg::ST_EMIT);
  assign node_index    = 6'(e_n);
  assign unreachable   = !reached[e_n];
  assign distance      = reached[e_n] ? dist_rd : '0;
  assign edges_dropped = overflow;
  assign last          = (emit_idx == (NB+1)'(cnt - 7'd1));
  assign busy          = (state != sssp_pkg::ST_IDLE);

endmodule

@@ sim/sssp_distance_checker.sv @@
`timescale 1ns / 1ps

module sssp_distance_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  node_count,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [5:0]  edge_end_a,
  input  logic [5:0]  edge_end_b,
  input  logic [15:0] edge_weight,
  input  logic [5:0]  source_node,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  node_index,
  input  logic [21:0] distance,
  input  logic        unreachable,
  input  logic        edges_dropped,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  localparam int EDGE_CAP = 1024;
  localparam int NODE_CAP = 64;

  typedef struct {
    logic [5:0]  node;
    logic [21:0] dist_val;
    logic        unreach;
    logic        dropped;
    logic        last;
  } node_dist_t;

  // predicted graph state
  logic [5:0]  edge_a_q [EDGE_CAP];
  logic [5:0]  edge_b_q [EDGE_CAP];
  logic [15:0] edge_w_q [EDGE_CAP];
  int          edge_fill;
  bit          dropped_flag;
  int          active_nodes;
  node_dist_t  dist_queue [$];

  assign pending = dist_queue.size();

  // relax one edge direction into the distance table
  task automatic relax_node(int to, longint base, int w, ref longint d[NODE_CAP],
                            ref bit reached[NODE_CAP]);
    longint cand;
    cand = base + w;
    if (cand > longint'(sssp_pkg::DIST_MAX)) cand = longint'(sssp_pkg::DIST_MAX);
    if (!reached[to] || cand < d[to]) begin
      d[to] = cand;
      reached[to] = 1'b1;
    end
  endtask

  // full Dijkstra run from src, pushes one expectation per active node
  task automatic predict_distances(int src);
    longint d [NODE_CAP];
    bit     reached [NODE_CAP];
    bit     settled [NODE_CAP];
    int     u;
    bit     found;
    node_dist_t r;
    for (int i = 0; i < NODE_CAP; i++) begin
      reached[i] = 0;
      settled[i] = 0;
      d[i] = 0;
    end
    if (src < active_nodes) begin
      reached[src] = 1'b1;
      forever begin
        found = 0;
        u = 0;
        for (int i = 0; i < active_nodes; i++) begin
          if (reached[i] && !settled[i] && (!found || d[i] < d[u])) begin
            u = i;
            found = 1;
          end
        end
        if (!found) break;
        settled[u] = 1'b1;
        for (int e = 0; e < edge_fill; e++) begin
          if (edge_a_q[e] >= active_nodes || edge_b_q[e] >= active_nodes) continue;
          if (edge_a_q[e] == u) relax_node(edge_b_q[e], d[u], edge_w_q[e], d, reached);
          if (edge_b_q[e] == u) relax_node(edge_a_q[e], d[u], edge_w_q[e], d, reached);
        end
      end
    end
    for (int i = 0; i < active_nodes; i++) begin
      r.node     = 6'(i);
      r.dist_val = reached[i] ? d[i][21:0] : '0;
      r.unreach  = !reached[i];
      r.dropped  = dropped_flag;
      r.last     = (i + 1 == active_nodes);
      dist_queue.push_back(r);
    end
  endtask

  // watch all three channels
  always @(posedge clk) begin
    node_dist_t exp_r;
    int v;
    if (rst) begin
      edge_fill    = 0;
      dropped_flag = 0;
      active_nodes = NODE_CAP;
      dist_queue.delete();
      fail_count   = 0;
    end else begin
      // config write
      if (cfg_valid && cfg_ready) begin
        v = int'(node_count);
        if (v < 1) v = 1;
        if (v > NODE_CAP) v = NODE_CAP;
        active_nodes = v;
      end
      // request
      if (in_valid && !in_stall) begin
        case (sssp_pkg::req_type_t'(req_type))
          sssp_pkg::REQ_ADD: begin
            if (edge_fill >= EDGE_CAP) begin
              dropped_flag = 1'b1;
            end else begin
              edge_a_q[edge_fill] = edge_end_a;
              edge_b_q[edge_fill] = edge_end_b;
              edge_w_q[edge_fill] = edge_weight;
              edge_fill++;
            end
          end
          sssp_pkg::REQ_RUN:   predict_distances(int'(source_node));
          sssp_pkg::REQ_CLEAR: edge_fill = 0;
          default: ;
        endcase
      end
      // result
      if (out_valid && !out_stall) begin
        if (dist_queue.size() == 0) begin
          $error("unexpected result node_index %0d", node_index);
          fail_count++;
        end else begin
          exp_r = dist_queue.pop_front();
          if (node_index !== exp_r.node) begin
            $error("node_index exp %0d got %0d", exp_r.node, node_index);
            fail_count++;
          end
          if (distance !== exp_r.dist_val) begin
            $error("distance exp %0d got %0d", exp_r.dist_val, distance);
            fail_count++;
          end
          if (unreachable !== exp_r.unreach) begin
            $error("unreachable exp %0d got %0d", exp_r.unreach, unreachable);
            fail_count++;
          end
          if (edges_dropped !== exp_r.dropped) begin
            $error("edges_dropped exp %0d got %0d", exp_r.dropped, edges_dropped);
            fail_count++;
          end
          if (last !== exp_r.last) begin
            $error("last exp %0d got %0d", exp_r.last, last);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ sim/single_source_shortest_path_unit_tb.sv @@
`timescale 1ns / 1ps

module single_source_shortest_path_unit_tb;

  localparam int QUIET_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 64;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  node_count;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [5:0]  edge_end_a;
  logic [5:0]  edge_end_b;
  logic [15:0] edge_weight;
  logic [5:0]  source_node;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  node_index;
  logic [21:0] distance;
  logic        unreachable;
  logic        edges_dropped;
  logic        last;

  int fail_count;
  int pending;
  int quiet_cycles;
  bit idle_en;
  int cur_nodes;
  int phase_edges;

  single_source_shortest_path_unit dut (.*);

  sssp_distance_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // receiver stall
  always @(posedge clk) begin
    out_stall <= idle_en && ($urandom_range(0, 99) < 29);
  end

  // watchdog on channel activity
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_request(sssp_pkg::req_type_t kind, int a, int b, int w, int src);
    while (idle_en && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    edge_end_a  <= 6'(a);
    edge_end_b  <= 6'(b);
    edge_weight <= 16'(w);
    source_node <= 6'(src);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every expected result is in, then let the back end drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(int v);
    cfg_valid  <= 1'b1;
    node_count <= 7'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_nodes = (v < 1) ? 1 : (v > 64) ? 64 : v;
  endtask

  function automatic int pick_node();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, cur_nodes - 1);
    return $urandom_range(0, 63);
  endfunction

  // random phase: mostly edge builds followed by runs
  task automatic random_phase(int n_req, int edge_cap);
    int r;
    int w;
    phase_edges = 0;
    send_request(sssp_pkg::REQ_CLEAR, 0, 0, 0, 0);
    for (int k = 0; k < n_req; k++) begin
      r = $urandom_range(0, 99);
      w = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20);
      if (r < 70 && phase_edges < edge_cap) begin
        send_request(sssp_pkg::REQ_ADD, pick_node(), pick_node(), w, $urandom_range(0, 63));
        phase_edges++;
      end else if (r < 90 || phase_edges >= edge_cap) begin
        send_request(sssp_pkg::REQ_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 65535), pick_node());
      end else if (r < 95) begin
        send_request(sssp_pkg::REQ_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 65535), $urandom_range(0, 63));
        phase_edges = 0;
      end else begin
        send_request(sssp_pkg::REQ_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 65535), $urandom_range(0, 63));
        k--;
      end
    end
    send_request(sssp_pkg::REQ_RUN, 0, 0, 0, pick_node());
    drain();
  endtask

  initial begin
    rst         = 1'b1;
    idle_en     = 1'b1;
    cfg_valid   = 1'b0;
    node_count  = 7'd64;
    in_valid    = 1'b0;
    req_type    = sssp_pkg::REQ_NONE;
    edge_end_a  = '0;
    edge_end_b  = '0;
    edge_weight = '0;
    source_node = '0;
    out_stall   = 1'b0;
    cur_nodes   = 64;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: small graph, self loop, out-of-range endpoint and source
    write_node_count(8);
    send_request(sssp_pkg::REQ_ADD, 0, 1, 5, 0);
    send_request(sssp_pkg::REQ_ADD, 1, 2, 3, 0);
    send_request(sssp_pkg::REQ_ADD, 0, 2, 10, 0);
    send_request(sssp_pkg::REQ_ADD, 2, 2, 7, 0);
    send_request(sssp_pkg::REQ_ADD, 3, 9, 1, 0);
    send_request(sssp_pkg::REQ_ADD, 4, 5, 65535, 0);
    send_request(sssp_pkg::REQ_ADD, 5, 7, 0, 0);
    send_request(sssp_pkg::REQ_RUN, 0, 0, 0, 0);
    send_request(sssp_pkg::REQ_RUN, 0, 0, 0, 9);
    send_request(sssp_pkg::REQ_RUN, 0, 0, 0, 4);
    send_request(sssp_pkg::REQ_NONE, 63, 63, 65535, 63);
    send_request(sssp_pkg::REQ_CLEAR, 0, 0, 0, 0);
    send_request(sssp_pkg::REQ_RUN, 0, 0, 0, 0);
    drain();

    // node count of zero is held as one
    write_node_count(0);
    send_request(sssp_pkg::REQ_RUN, 0, 0, 0, 0);
    send_request(sssp_pkg::REQ_RUN, 0, 0, 0, 63);
    drain();

    // oversized count is held at the maximum; top node indexes
    write_node_count(127);
    send_request(sssp_pkg::REQ_ADD, 63, 0, 0, 0);
    send_request(sssp_pkg::REQ_ADD, 62, 63, 1, 0);
    send_request(sssp_pkg::REQ_ADD, 62, 0, 65535, 0);
    send_request(sssp_pkg::REQ_RUN, 0, 0, 0, 63);
    send_request(sssp_pkg::REQ_CLEAR, 0, 0, 0, 0);
    drain();

    // random phases over several node counts
    write_node_count(64);
    random_phase(14, 40);
    write_node_count($urandom_range(2, 12));
    random_phase(16, 30);
    idle_en = 1'b0;
    write_node_count(1);
    random_phase(10, 10);
    write_node_count($urandom_range(13, 40));
    random_phase(16, 40);
    idle_en = 1'b1;
    write_node_count($urandom_range(2, 8));
    random_phase(16, 30);
    write_node_count(64);
    random_phase(14, 40);

    // two-node graph after a clear, run from the far end
    write_node_count(2);
    send_request(sssp_pkg::REQ_CLEAR, 0, 0, 0, 0);
    send_request(sssp_pkg::REQ_ADD, 0, 1, 9, 0);
    send_request(sssp_pkg::REQ_RUN, 0, 0, 0, 1);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
